// File: hw/rtl/akf_pkg.sv
// Shared types, codes, widths and fixed-point helpers of the altitude Kalman filter.
package akf_pkg;

    localparam int DataW   = 32;
    localparam int DtW     = 16;
    localparam int NoiseW  = 31;
    localparam int ActW    = 2;
    localparam int CfgIdxW = 1;
    localparam int MulXW   = 48;
    localparam int MulYW   = 32;
    localparam int ProdW   = MulXW + 1 + MulYW;
    localparam int WideW   = ProdW + 2;
    localparam int DivNumW = 48;
    localparam int DivDenW = 33;
    localparam int FracW   = 16;

    typedef logic signed [DataW-1:0] t_data;
    typedef logic signed [WideW-1:0] t_wide;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [ActW-1:0] {
        ACT_PREDICT = 2'd0,
        ACT_UPDATE  = 2'd1,
        ACT_RESET   = 2'd2,
        ACT_HOLD    = 2'd3
    } t_action;

    localparam logic [CfgIdxW-1:0] CFG_PROCESS_NOISE = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_MEASURE_NOISE = 1'b1;

    typedef logic [2:0] t_op;

    // predict sequence
    localparam t_op OP_P_DP11 = 3'd0;
    localparam t_op OP_P_COV  = 3'd1;
    localparam t_op OP_P_VEL  = 3'd2;
    localparam t_op OP_P_ACC  = 3'd3;
    localparam t_op OP_P_ALT  = 3'd4;
    // update sequence
    localparam t_op OP_U_K0   = 3'd0;
    localparam t_op OP_U_K1   = 3'd1;
    localparam t_op OP_U_P10  = 3'd2;
    localparam t_op OP_U_P00  = 3'd3;
    localparam t_op OP_U_P11  = 3'd4;
    localparam t_op OP_U_P01  = 3'd5;
    localparam t_op OP_U_ALT  = 3'd6;
    localparam t_op OP_U_VEL  = 3'd7;

    localparam t_data               ONE_Q16      = 32'sh0001_0000;
    localparam logic [NoiseW-1:0]   PNOISE_RESET = 31'd6554;
    localparam logic [NoiseW-1:0]   MNOISE_RESET = 31'd65536;

    // round 32 fraction bits to 16, half up
    function automatic t_wide rnd16(input t_wide x);
        return (x + t_wide'(32768)) >>> FracW;
    endfunction

    function automatic t_data sat32(input t_wide x);
        t_wide hi;
        t_wide lo;
        hi = t_wide'(t_data'(32'h7fff_ffff));
        lo = t_wide'(t_data'(32'h8000_0000));
        if (x > hi) begin
            return t_data'(32'h7fff_ffff);
        end
        if (x < lo) begin
            return t_data'(32'h8000_0000);
        end
        return x[DataW-1:0];
    endfunction

endpackage

// File: hw/rtl/akf_if.sv
// Handshake channels of the altitude Kalman filter: input, result and register write.
interface akf_in_if;
    logic                              valid;
    logic                              ready;
    logic [akf_pkg::ActW-1:0]          action;
    logic signed [akf_pkg::DataW-1:0]  accel_z;
    logic [akf_pkg::DtW-1:0]           time_step;
    logic signed [akf_pkg::DataW-1:0]  altitude_in;

    modport source (output valid, action, accel_z, time_step, altitude_in, input ready);
    modport sink   (input valid, action, accel_z, time_step, altitude_in, output ready);
endinterface

interface akf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [akf_pkg::DataW-1:0]  altitude_out;
    logic signed [akf_pkg::DataW-1:0]  velocity_out;

    modport source (output valid, altitude_out, velocity_out, input ready);
    modport sink   (input valid, altitude_out, velocity_out, output ready);
endinterface

interface akf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [akf_pkg::CfgIdxW-1:0]       index;
    logic [akf_pkg::DataW-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/akf_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add with final subtract.
module akf_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [akf_pkg::MulXW-1:0]    i_x,
    input  logic signed [akf_pkg::MulYW-1:0]    i_y,
    output logic                                o_done,
    output logic signed [akf_pkg::ProdW-1:0]    o_prod
);

    localparam int CntW = $clog2(akf_pkg::MulYW);

    logic signed [akf_pkg::MulXW:0]   r_x;
    logic signed [akf_pkg::MulXW:0]   r_acc;
    logic [akf_pkg::MulYW-1:0]        r_yq;
    logic [CntW-1:0]                  r_cnt;
    logic                             r_busy;
    logic                             r_done;

    logic                             last;
    logic signed [akf_pkg::MulXW:0]   addend;
    logic signed [akf_pkg::MulXW:0]   sum;

    always_comb begin
        last   = (r_cnt == CntW'(akf_pkg::MulYW - 1));
        addend = '0;
        if (r_yq[0]) begin
            addend = last ? -r_x : r_x;
        end
        sum = r_acc + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift the partial product right, pulling its low bit into the multiplier register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= (akf_pkg::MulXW + 1)'(i_x);
            r_acc <= '0;
            r_yq  <= i_y;
        end else if (r_busy) begin
            r_acc <= sum >>> 1;
            r_yq  <= {sum[0], r_yq[akf_pkg::MulYW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_acc, r_yq};

endmodule

// File: hw/rtl/akf_div.sv
// Radix-2 restoring divider: one quotient bit per cycle, truncating, saturated to Q16.16.
module akf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [akf_pkg::DivNumW-1:0]  i_num,
    input  logic signed [akf_pkg::DivDenW-1:0]  i_den,
    output logic                                o_done,
    output logic signed [akf_pkg::DataW-1:0]    o_quo
);

    localparam int CntW = $clog2(akf_pkg::DivNumW);
    localparam logic [akf_pkg::DivNumW-1:0] PosMax = akf_pkg::DivNumW'(32'h7fff_ffff);
    localparam logic [akf_pkg::DivNumW-1:0] NegMax = akf_pkg::DivNumW'(32'h8000_0000);

    logic [akf_pkg::DivNumW-1:0]  r_nq;
    logic [akf_pkg::DivDenW-1:0]  r_rem;
    logic [akf_pkg::DivDenW-1:0]  r_d;
    logic                         r_neg;
    logic                         r_zero;
    logic [CntW-1:0]              r_cnt;
    logic                         r_busy;
    logic                         r_done;

    logic [akf_pkg::DivDenW:0]    trial;
    logic [akf_pkg::DivDenW:0]    diff;
    logic                         ge;

    always_comb begin
        trial = {r_rem, r_nq[akf_pkg::DivNumW-1]};
        diff  = trial - {1'b0, r_d};
        ge    = (trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(akf_pkg::DivNumW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq   <= i_num[akf_pkg::DivNumW-1] ? akf_pkg::DivNumW'(-i_num)
                                                : akf_pkg::DivNumW'(i_num);
            r_d    <= i_den[akf_pkg::DivDenW-1] ? akf_pkg::DivDenW'(-i_den)
                                                : akf_pkg::DivDenW'(i_den);
            r_rem  <= '0;
            r_neg  <= i_num[akf_pkg::DivNumW-1] ^ i_den[akf_pkg::DivDenW-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= ge ? diff[akf_pkg::DivDenW-1:0] : trial[akf_pkg::DivDenW-1:0];
            r_nq  <= {r_nq[akf_pkg::DivNumW-2:0], ge};
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quo = '0;
        end else if (!r_neg) begin
            o_quo = (r_nq > PosMax) ? akf_pkg::t_data'(32'h7fff_ffff)
                                    : akf_pkg::t_data'(r_nq[akf_pkg::DataW-1:0]);
        end else begin
            o_quo = (r_nq > NegMax) ? akf_pkg::t_data'(32'h8000_0000)
                                    : akf_pkg::t_data'(-r_nq[akf_pkg::DataW-1:0]);
        end
    end

    assign o_done = r_done;

endmodule

// File: hw/rtl/altitude_kalman_filter.sv
// Top level of the two-state altitude Kalman filter with a serial multiply/divide sequencer.
//
//  port    | dir | role                    | payload
//  --------+-----+-------------------------+-----------------------------------------------
//  i_in    | in  | one request per step    | action, accel_z, time_step, altitude_in
//  o_out   | out | one result per request  | altitude_out, velocity_out
//  i_cfg   | in  | register write          | index (0 process noise, 1 measure noise), data
//
// Sequence: predict runs five serial multiplications; update runs two 48-step divisions
//   and six multiplications (a division by a zero innovation variance skips its steps);
//   reset and the unused action go straight to the result.
// Reset: synchronous, active low; altitude and velocity clear, covariance loads identity,
//   noise registers load their defaults.
// Stalls: a finished result moves into the output register and the sequencer returns to
//   idle; it holds only if a second result is done while the first still waits.
module altitude_kalman_filter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    akf_in_if.sink    i_in,
    akf_out_if.source o_out,
    akf_cfg_if.sink   i_cfg
);

    // ---------------------------------------------------------------- state
    akf_pkg::t_state  r_state;
    akf_pkg::t_state  n_state;
    akf_pkg::t_action r_act;
    akf_pkg::t_op     r_op;
    logic             r_launch;

    akf_pkg::t_data   r_alt;
    akf_pkg::t_data   r_vel;
    akf_pkg::t_data   r_p00;
    akf_pkg::t_data   r_p01;
    akf_pkg::t_data   r_p10;
    akf_pkg::t_data   r_p11;
    logic [akf_pkg::NoiseW-1:0] r_q;
    logic [akf_pkg::NoiseW-1:0] r_r;

    // request payload and scratch values of the running sequence
    akf_pkg::t_data                        r_accel;
    logic [akf_pkg::DtW-1:0]               r_dt;
    logic signed [akf_pkg::DataW+1:0]      r_dp11;
    akf_pkg::t_data                        r_vtmp;
    logic signed [akf_pkg::MulXW-1:0]      r_adt;
    logic signed [akf_pkg::MulXW-1:0]      r_acc2;
    logic signed [akf_pkg::DivDenW-1:0]    r_s;
    logic signed [akf_pkg::DivDenW-1:0]    r_y;
    akf_pkg::t_data                        r_k0;
    akf_pkg::t_data                        r_k1;

    logic             r_o_valid;
    akf_pkg::t_data   r_o_alt;
    akf_pkg::t_data   r_o_vel;

    // ---------------------------------------------------------------- handshakes
    logic in_ready;
    logic in_accept;
    logic cfg_accept;
    logic mul_start;
    logic div_start;
    logic out_load;
    logic mul_last;

    logic                                   mul_done;
    logic signed [akf_pkg::ProdW-1:0]       mul_prod;
    logic signed [akf_pkg::MulXW-1:0]       mul_x;
    logic signed [akf_pkg::MulYW-1:0]       mul_y;
    logic                                   div_done;
    akf_pkg::t_data                         div_quo;
    logic signed [akf_pkg::DivNumW-1:0]     div_num;

    akf_pkg::t_wide w_prod;
    akf_pkg::t_wide w_rnd;
    akf_pkg::t_wide w_alt_pred;

    assign in_accept  = i_in.valid && in_ready;
    assign cfg_accept = i_cfg.valid;   // always ready
    assign mul_last   = (r_act == akf_pkg::ACT_PREDICT) ? (r_op == akf_pkg::OP_P_ALT)
                                                        : (r_op == akf_pkg::OP_U_VEL);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            akf_pkg::ST_IDLE: begin
                if (in_accept) begin
                    priority if (akf_pkg::t_action'(i_in.action) == akf_pkg::ACT_PREDICT) begin
                        n_state = akf_pkg::ST_MUL;
                    end else if (akf_pkg::t_action'(i_in.action) == akf_pkg::ACT_UPDATE) begin
                        n_state = akf_pkg::ST_DIV;
                    end else begin
                        n_state = akf_pkg::ST_DONE;
                    end
                end
            end
            akf_pkg::ST_MUL: begin
                if (mul_done && mul_last) begin
                    n_state = akf_pkg::ST_DONE;
                end
            end
            akf_pkg::ST_DIV: begin
                if (div_done && (r_op == akf_pkg::OP_U_K1)) begin
                    n_state = akf_pkg::ST_MUL;
                end
            end
            akf_pkg::ST_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_state = akf_pkg::ST_IDLE;
                end
            end
            default: n_state = akf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (r_state == akf_pkg::ST_IDLE);
        mul_start = (r_state == akf_pkg::ST_MUL) && r_launch;
        div_start = (r_state == akf_pkg::ST_DIV) && r_launch;
        out_load  = (r_state == akf_pkg::ST_DONE) && (!r_o_valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= akf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------- operand select
    always_comb begin
        mul_x = '0;
        mul_y = akf_pkg::MulYW'({16'b0, r_dt});
        if (r_act == akf_pkg::ACT_PREDICT) begin
            unique case (r_op)
                akf_pkg::OP_P_DP11: mul_x = akf_pkg::MulXW'(r_p11);
                akf_pkg::OP_P_COV:  mul_x = akf_pkg::MulXW'(r_p10) + akf_pkg::MulXW'(r_p01)
                                          + akf_pkg::MulXW'(r_dp11);
                akf_pkg::OP_P_VEL:  mul_x = akf_pkg::MulXW'(r_accel);
                akf_pkg::OP_P_ACC:  mul_x = r_adt;
                akf_pkg::OP_P_ALT:  mul_x = akf_pkg::MulXW'(r_vel);
                default:            mul_x = '0;
            endcase
        end else begin
            unique case (r_op)
                akf_pkg::OP_U_P10: begin mul_x = akf_pkg::MulXW'(r_p00); mul_y = r_k1; end
                akf_pkg::OP_U_P00: begin mul_x = akf_pkg::MulXW'(r_p00); mul_y = r_k0; end
                akf_pkg::OP_U_P11: begin mul_x = akf_pkg::MulXW'(r_p01); mul_y = r_k1; end
                akf_pkg::OP_U_P01: begin mul_x = akf_pkg::MulXW'(r_p01); mul_y = r_k0; end
                akf_pkg::OP_U_ALT: begin mul_x = akf_pkg::MulXW'(r_y);   mul_y = r_k0; end
                akf_pkg::OP_U_VEL: begin mul_x = akf_pkg::MulXW'(r_y);   mul_y = r_k1; end
                default:           begin mul_x = '0;                     mul_y = '0;   end
            endcase
        end
        // gain numerators carry 16 extra fraction bits
        div_num = (r_op == akf_pkg::OP_U_K0) ? (akf_pkg::DivNumW'(r_p00) <<< akf_pkg::FracW)
                                             : (akf_pkg::DivNumW'(r_p10) <<< akf_pkg::FracW);
    end

    akf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    akf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        w_prod     = akf_pkg::t_wide'(mul_prod);
        w_rnd      = akf_pkg::rnd16(w_prod);
        w_alt_pred = akf_pkg::rnd16(w_prod + akf_pkg::t_wide'(r_acc2));
    end

    // ---------------------------------------------------------------- filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt    <= '0;
            r_vel    <= '0;
            r_p00    <= akf_pkg::ONE_Q16;
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= akf_pkg::ONE_Q16;
            r_q      <= akf_pkg::PNOISE_RESET;
            r_r      <= akf_pkg::MNOISE_RESET;
            r_launch <= 1'b0;
            r_op     <= '0;
            r_act    <= akf_pkg::ACT_HOLD;
        end else begin
            if (cfg_accept) begin
                unique case (i_cfg.index)
                    akf_pkg::CFG_PROCESS_NOISE: r_q <= i_cfg.data[akf_pkg::NoiseW-1:0];
                    akf_pkg::CFG_MEASURE_NOISE: r_r <= i_cfg.data[akf_pkg::NoiseW-1:0];
                    default: ;
                endcase
            end

            if (in_accept) begin
                r_act   <= akf_pkg::t_action'(i_in.action);
                r_accel <= i_in.accel_z;
                r_dt    <= i_in.time_step;
                r_op    <= '0;
                r_s     <= akf_pkg::DivDenW'(r_p00) + akf_pkg::DivDenW'({1'b0, r_r});
                r_y     <= akf_pkg::DivDenW'(i_in.altitude_in) - akf_pkg::DivDenW'(r_alt);
                unique case (akf_pkg::t_action'(i_in.action))
                    akf_pkg::ACT_PREDICT,
                    akf_pkg::ACT_UPDATE: r_launch <= 1'b1;
                    akf_pkg::ACT_RESET: begin
                        r_alt <= i_in.altitude_in;
                        r_vel <= '0;
                        r_p00 <= akf_pkg::ONE_Q16;
                        r_p01 <= '0;
                        r_p10 <= '0;
                        r_p11 <= akf_pkg::ONE_Q16;
                    end
                    default: ;
                endcase
            end else if (mul_start || div_start) begin
                r_launch <= 1'b0;
            end

            if (div_done) begin
                if (r_op == akf_pkg::OP_U_K0) begin
                    r_k0 <= div_quo;
                end else begin
                    r_k1 <= div_quo;
                end
                r_op     <= r_op + 1'b1;
                r_launch <= 1'b1;
            end

            // retire one multiplication and advance the sequence
            if (mul_done) begin
                r_op     <= r_op + 1'b1;
                r_launch <= !mul_last;
                if (r_act == akf_pkg::ACT_PREDICT) begin
                    unique case (r_op)
                        akf_pkg::OP_P_DP11: r_dp11 <= w_rnd[akf_pkg::DataW+1:0];
                        akf_pkg::OP_P_COV: begin
                            r_p00 <= akf_pkg::sat32(akf_pkg::t_wide'(r_p00) + w_rnd
                                                    + akf_pkg::t_wide'({1'b0, r_q}));
                            r_p01 <= akf_pkg::sat32(akf_pkg::t_wide'(r_p01)
                                                    + akf_pkg::t_wide'(r_dp11));
                            r_p10 <= akf_pkg::sat32(akf_pkg::t_wide'(r_p10)
                                                    + akf_pkg::t_wide'(r_dp11));
                            r_p11 <= akf_pkg::sat32(akf_pkg::t_wide'(r_p11)
                                                    + akf_pkg::t_wide'({1'b0, r_q}));
                        end
                        akf_pkg::OP_P_VEL: begin
                            r_adt  <= mul_prod[akf_pkg::MulXW-1:0];
                            r_vtmp <= akf_pkg::sat32(akf_pkg::t_wide'(r_vel) + w_rnd);
                        end
                        akf_pkg::OP_P_ACC: begin
                            // floor of a*dt*dt over 2^17
                            r_acc2 <= mul_prod[akf_pkg::MulXW+16:17];
                        end
                        akf_pkg::OP_P_ALT: begin
                            r_alt <= akf_pkg::sat32(akf_pkg::t_wide'(r_alt) + w_alt_pred);
                            r_vel <= r_vtmp;
                        end
                        default: ;
                    endcase
                end else begin
                    unique case (r_op)
                        akf_pkg::OP_U_P10:
                            r_p10 <= akf_pkg::sat32(akf_pkg::t_wide'(r_p10) - w_rnd);
                        akf_pkg::OP_U_P00:
                            r_p00 <= akf_pkg::sat32(akf_pkg::t_wide'(r_p00) - w_rnd);
                        akf_pkg::OP_U_P11:
                            r_p11 <= akf_pkg::sat32(akf_pkg::t_wide'(r_p11) - w_rnd);
                        akf_pkg::OP_U_P01:
                            r_p01 <= akf_pkg::sat32(akf_pkg::t_wide'(r_p01) - w_rnd);
                        akf_pkg::OP_U_ALT:
                            r_alt <= akf_pkg::sat32(akf_pkg::t_wide'(r_alt) + w_rnd);
                        akf_pkg::OP_U_VEL:
                            r_vel <= akf_pkg::sat32(akf_pkg::t_wide'(r_vel) + w_rnd);
                        default: ;
                    endcase
                end
            end
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_alt <= r_alt;
            r_o_vel <= r_vel;
        end
    end

    assign i_in.ready         = in_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_o_valid;
    assign o_out.altitude_out = r_o_alt;
    assign o_out.velocity_out = r_o_vel;

    // ---------------------------------------------------------------- checks
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_start && div_start))
        else $error("multiplier and divider launched together");

    a_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == akf_pkg::ST_MUL))
        else $error("product returned outside the multiply phase");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == akf_pkg::ST_DIV))
        else $error("quotient returned outside the divide phase");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != akf_pkg::ST_IDLE))
        else $error("accepted request left the sequencer idle");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == akf_pkg::ST_DONE))
        else $error("result raised without a finished request");

endmodule

// File: sim/akf_tb_if.sv
// Channel interfaces for the testbench are shared with the RTL in akf_if.sv.

// File: sim/testbench.sv
// Self-checking testbench of the altitude Kalman filter: predicts every result from the request.
class akf_scoreboard;
    logic [30:0]        proc_noise;
    logic [30:0]        meas_noise;
    logic signed [31:0] alt;
    logic signed [31:0] vel;
    logic signed [31:0] cov [4];
    logic signed [31:0] exp_alt [$];
    logic signed [31:0] exp_vel [$];
    int                 n_fail;
    int                 n_seen;

    function new();
        proc_noise = 31'd6554;
        meas_noise = 31'd65536;
        alt = 0;
        vel = 0;
        cov[0] = 32'sh10000;
        cov[1] = 0;
        cov[2] = 0;
        cov[3] = 32'sh10000;
        n_fail = 0;
        n_seen = 0;
    endfunction

    // round 32 fraction bits to 16, half up; arithmetic shift floors
    static function longint round_q16(longint x);
        return ((x >>> 15) + 1) >>> 1;
    endfunction

    static function logic signed [31:0] clip(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    static function longint gain_of(longint num, longint s);
        if (s == 0) return 0;
        return clip((num * 65536) / s);
    endfunction

    function void write_reg(bit idx, logic [31:0] d);
        if (idx == akf_pkg::CFG_PROCESS_NOISE) proc_noise = d[30:0];
        else meas_noise = d[30:0];
    endfunction

    // advance the filter state by one request and queue the estimate it leaves
    function void note_request(akf_pkg::t_action act, logic signed [31:0] acc,
                               logic [15:0] dt_u, logic signed [31:0] meas_in);
        longint z, v, p00, p01, p10, p11, a, dt, q, dp11, w, s, k0, k1, y, m;
        z = alt; v = vel; p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
        a = acc; dt = dt_u; m = meas_in;
        case (act)
            akf_pkg::ACT_PREDICT: begin
                q = proc_noise;
                dp11 = round_q16(dt * p11);
                w = p10 + p01 + dp11;
                alt = clip(z + round_q16(v * dt + ((a * (dt * dt)) >>> 17)));
                vel = clip(v + round_q16(a * dt));
                cov[0] = clip(p00 + round_q16(dt * w) + q);
                cov[1] = clip(p01 + dp11);
                cov[2] = clip(p10 + dp11);
                cov[3] = clip(p11 + q);
            end
            akf_pkg::ACT_UPDATE: begin
                s = p00 + longint'(meas_noise);
                k0 = gain_of(p00, s);
                k1 = gain_of(p10, s);
                y = m - z;
                alt = clip(z + round_q16(k0 * y));
                vel = clip(v + round_q16(k1 * y));
                cov[0] = clip(p00 - round_q16(k0 * p00));
                cov[1] = clip(p01 - round_q16(k0 * p01));
                cov[2] = clip(p10 - round_q16(k1 * p00));
                cov[3] = clip(p11 - round_q16(k1 * p01));
            end
            akf_pkg::ACT_RESET: begin
                alt = meas_in;
                vel = 0;
                cov[0] = 32'sh10000; cov[1] = 0; cov[2] = 0; cov[3] = 32'sh10000;
            end
            default: ;
        endcase
        exp_alt.push_back(alt);
        exp_vel.push_back(vel);
    endfunction

    function void check_result(logic signed [31:0] a_out, logic signed [31:0] v_out);
        logic signed [31:0] ea;
        logic signed [31:0] ev;
        n_seen++;
        if (exp_alt.size() == 0) begin
            $error("result with no request pending: altitude_out %0d", a_out);
            n_fail++;
            return;
        end
        ea = exp_alt.pop_front();
        ev = exp_vel.pop_front();
        if (a_out !== ea) begin
            $error("altitude_out expected %0d actual %0d", ea, a_out);
            n_fail++;
        end
        if (v_out !== ev) begin
            $error("velocity_out expected %0d actual %0d", ev, v_out);
            n_fail++;
        end
    endfunction

    function int pending();
        return exp_alt.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    akf_in_if  in_ch();
    akf_out_if out_ch();
    akf_cfg_if cfg_ch();

    altitude_kalman_filter uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    akf_scoreboard board = new();

    // receiver behavior: random stall per result, or a long hold-off when asked
    bit stall_random = 1'b0;
    bit hold_off = 1'b0;
    int n_predict = 0;
    int n_update = 0;
    int n_reset = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = akf_pkg::ACT_PREDICT;
        in_ch.accel_z = '0;
        in_ch.time_step = '0;
        in_ch.altitude_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Limit: the slowest request plus gaps and stalls, several times over
    initial begin
        #(4ns * 2000000);
        $display("testbench NOT OK");
        $finish;
    end

    // Check every result accepted at the edge; sample before the drivers update.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_result(out_ch.altitude_out, out_ch.velocity_out);
        end
    end

    // Drive ready: hold low over the long hold-off, otherwise random stalls while enabled.
    initial begin : receiver
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                gap = 3000;
                hold_off = 1'b0;
            end else begin
                gap = stall_random ? $urandom_range(0, 11) : 0;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk iff out_ch.valid && out_ch.ready);
        end
    end

    task automatic write_reg(bit idx, logic [31:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge i_clk iff cfg_ch.ready);
        board.write_reg(idx, d);
        cfg_ch.valid <= 1'b0;
    endtask

    // Offer one request, hold it until accepted, and note it for prediction.
    task automatic send_request(akf_pkg::t_action act, logic [31:0] acc, logic [15:0] dt,
                                logic [31:0] meas, int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.accel_z     <= acc;
        in_ch.time_step   <= dt;
        in_ch.altitude_in <= meas;
        @(posedge i_clk iff in_ch.ready);
        board.note_request(act, acc, dt, meas);
        case (act)
            akf_pkg::ACT_PREDICT: n_predict++;
            akf_pkg::ACT_UPDATE:  n_update++;
            akf_pkg::ACT_RESET:   n_reset++;
            default: ;
        endcase
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word(int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    // one random request: mostly moderate values, some wide noise and extremes
    task automatic random_request(int gap);
        int r;
        akf_pkg::t_action act;
        r = $urandom_range(0, 99);
        if (r < 55) act = akf_pkg::ACT_PREDICT;
        else if (r < 88) act = akf_pkg::ACT_UPDATE;
        else if (r < 96) act = akf_pkg::ACT_RESET;
        else act = akf_pkg::ACT_HOLD;
        send_request(act, rand_word($urandom_range(0, 9) < 2 ? 0 : 2),
                     $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 700)),
                     rand_word($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2),
                     gap);
    endtask

    initial begin : stimulus
        logic [31:0] pn [4];
        logic [31:0] mn [4];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every action and each corner case
        send_request(akf_pkg::ACT_HOLD,    32'h0, 16'h0, 32'h0, 0);
        send_request(akf_pkg::ACT_PREDICT, 32'h0, 16'h0, 32'h0, 0);
        send_request(akf_pkg::ACT_PREDICT, 32'h7fffffff, 16'hffff, 32'h0, 1);
        send_request(akf_pkg::ACT_PREDICT, 32'h7fffffff, 16'hffff, 32'hffffffff, 0);
        send_request(akf_pkg::ACT_UPDATE,  32'h0, 16'h0, 32'h80000000, 0);
        send_request(akf_pkg::ACT_RESET,   32'hffffffff, 16'hffff, 32'h7fffffff, 2);
        send_request(akf_pkg::ACT_PREDICT, 32'h80000000, 16'hffff, 32'h0, 0);
        send_request(akf_pkg::ACT_UPDATE,  32'h0, 16'h0, 32'h80000000, 0);
        send_request(akf_pkg::ACT_RESET,   32'h0, 16'h0, 32'h80000000, 0);
        send_request(akf_pkg::ACT_UPDATE,  32'h0, 16'h0, 32'h7fffffff, 0);
        send_request(akf_pkg::ACT_HOLD,    32'hffffffff, 16'hffff, 32'hffffffff, 0);
        go_idle();
        // zero measure noise: update three times to drive P00 and S toward zero
        write_reg(akf_pkg::CFG_MEASURE_NOISE, 32'h0);
        write_reg(akf_pkg::CFG_PROCESS_NOISE, 32'h0);
        send_request(akf_pkg::ACT_RESET,  32'h0, 16'h0, 32'h0, 0);
        send_request(akf_pkg::ACT_UPDATE, 32'h0, 16'h0, 32'h00050000, 0);
        send_request(akf_pkg::ACT_UPDATE, 32'h0, 16'h0, 32'h00090000, 0);
        send_request(akf_pkg::ACT_UPDATE, 32'h0, 16'h0, 32'h7fffffff, 0);
        go_idle();
        // huge process noise, then full-scale dt so the covariance saturates
        write_reg(akf_pkg::CFG_PROCESS_NOISE, 32'h7fffffff);
        write_reg(akf_pkg::CFG_MEASURE_NOISE, 32'hffffffff);
        send_request(akf_pkg::ACT_PREDICT, 32'h00010000, 16'hffff, 32'h0, 0);
        send_request(akf_pkg::ACT_PREDICT, 32'h00010000, 16'hffff, 32'h0, 0);
        send_request(akf_pkg::ACT_UPDATE,  32'h0, 16'h0, 32'h80000000, 0);
        send_request(akf_pkg::ACT_PREDICT, 32'hfff00000, 16'h8000, 32'h0, 0);
        send_request(akf_pkg::ACT_UPDATE,  32'h0, 16'h0, 32'h12345678, 0);
        go_idle();

        // random phases across noise settings, extremes included
        pn = '{32'd6554, 32'd0, 32'h7fffffff, 32'd0};
        mn = '{32'd65536, 32'd1, 32'h7fffffff, 32'd0};
        stall_random = 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                pn[ph] = ph == 3 ? $urandom_range(0, 300000) : pn[ph];
                write_reg(akf_pkg::CFG_PROCESS_NOISE,
                          pn[ph] | {1'($urandom_range(0, 1)), 31'b0});
                write_reg(akf_pkg::CFG_MEASURE_NOISE, mn[ph]);
            end
            for (int i = 0; i < 130; i++) begin
                // bursts with no gaps alternate with random gaps
                random_request((i / 20) % 2 ? 0 : $urandom_range(0, 11));
                if (ph == 1 && i == 40) hold_off = 1'b1;
                if (i == 90) go_idle();
            end
            go_idle();
        end

        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("covered %0d predict, %0d update, %0d reset requests; %0d results checked",
                 n_predict, n_update, n_reset, board.n_seen);
        $display("noise registers swept through zero, defaults and full scale");
        if (board.n_fail == 0 && board.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
